// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the shell sort rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssfg_pkg.sv =====
// shared types and constants for the fixed-gap shell sort block
// no dependencies
`timescale 1ns / 1ps

package ssfg_pkg;

    localparam int VALUE_W   = 64;
    localparam int GAP_STEPS = 4;
    localparam int GAP_N     = 6;

    // gap table; the sort uses the first GAP_STEPS entries, largest first
    localparam logic [3:0] GAP_TABLE [GAP_N] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8};

    localparam logic [1:0] FIRST_STEP = 2'(GAP_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_CMP,
        ST_SWAP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOW,
        WR_HIGH
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    rd_en;
        wr_sel_t wr_sel;
        logic    emit;
        logic    emit_last;
    } cmd_t;

    function automatic logic [3:0] gap_of(input logic [1:0] step);
        gap_of = GAP_TABLE[{1'b0, step}];
    endfunction

endpackage

// ===== rtl/core/shell_sort_fixed_gaps_top.sv =====
// top level of the fixed-gap shell sort block
// depends on ssfg_pkg, ssfg_ctrl, ssfg_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - input: a transaction is taken at a clock edge with start high and busy low;
//   value is stored, is_last closes the set
// - values past MAX_ITEMS are discarded; dropped is then high on every result of the set
// - loading costs one cycle per value; busy stays low between values
// - after the last value the block sorts in place with gaps 4, 3, 2, 1; each gap
//   and start offset repeats passes until a pass makes no swap
// - each compare visits the pass and compare states, plus the swap state when it swaps,
//   since the store has a single write port and both elements of a swap are written
//   one after the other; a pass ends with a visit to the pass state
// - total sort time grows roughly with n squared
// - results: one transaction per stored value, ascending, each held for exactly
//   one cycle and marked by result_strobe; last_out marks the final one
// - readout runs one value per cycle from the registered store read port,
//   the first result in the cycle after readout begins
// - busy drops in the cycle that shows the final result, so the next set may
//   start loading right away
// - the receiver cannot stall; results are never held back
// - reset clears the state machine, element count, overflow flag and result strobe; the store
//   needs no clearing since only entries written for the current set are read

module shell_sort_fixed_gaps_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ssfg_pkg::VALUE_W-1:0] value,
    input  logic                                is_last,
    output logic                                result_strobe,
    output logic signed [ssfg_pkg::VALUE_W-1:0] sorted_value,
    output logic                                last_out,
    output logic                                dropped
);

    // store index and element count widths
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    ssfg_pkg::cmd_t   cmd;
    logic [IDX_W-1:0] addr_lo;
    logic [IDX_W-1:0] addr_hi;
    logic [CNT_W-1:0] count;
    logic             greater;

    // sequencer: owns gap step, start offset, pass index and swap flag
    ssfg_ctrl #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (is_last),
        .count   (count),
        .greater (greater),
        .busy    (busy),
        .cmd     (cmd),
        .addr_lo (addr_lo),
        .addr_hi (addr_hi)
    );

    // store with two read ports, signed comparator and result registers
    ssfg_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .addr_lo       (addr_lo),
        .addr_hi       (addr_hi),
        .value         (value),
        .count         (count),
        .greater       (greater),
        .sorted_value  (sorted_value),
        .result_strobe (result_strobe),
        .last_out      (last_out),
        .dropped       (dropped)
    );

    // a result is only ever produced by the readout phase
    `ASSERT_IMPLIES(a_result_from_readout, clk, rst_n, result_strobe, $past(busy),
        "result strobe without a preceding readout cycle")
    // once the final result is shown the block is free for a new set
    `ASSERT_IMPLIES(a_free_after_last, clk, rst_n, result_strobe && last_out, !busy,
        "block still busy when the final result is shown")

endmodule

// ===== rtl/core/ssfg_datapath.sv =====
// element store, element count, overflow flag and result registers
// depends on ssfg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssfg_datapath #(
    parameter int MAX_ITEMS = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssfg_pkg::cmd_t                      cmd,
    input  logic [IDX_W-1:0]                    addr_lo,
    input  logic [IDX_W-1:0]                    addr_hi,
    input  logic signed [ssfg_pkg::VALUE_W-1:0] value,
    output logic [CNT_W-1:0]                    count,
    output logic                                greater,
    output logic signed [ssfg_pkg::VALUE_W-1:0] sorted_value,
    output logic                                result_strobe,
    output logic                                last_out,
    output logic                                dropped
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    logic signed [ssfg_pkg::VALUE_W-1:0] mem [MAX_ITEMS];
    logic signed [ssfg_pkg::VALUE_W-1:0] rd_a_reg;
    logic signed [ssfg_pkg::VALUE_W-1:0] rd_b_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                overflow_reg;
    logic                                overflow_next;
    logic                                strobe_reg;
    logic                                last_reg;
    logic                                dropped_reg;
    logic                                room;

    assign room = (count_reg < MAX_CNT);

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[count_reg[IDX_W-1:0]] <= value;
        end
        else
        begin
            case (cmd.wr_sel)
                ssfg_pkg::WR_LOW:  mem[addr_lo] <= rd_b_reg;
                ssfg_pkg::WR_HIGH: mem[addr_hi] <= rd_a_reg;
                default: ;
            endcase
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[addr_lo];
            rd_b_reg <= mem[addr_hi];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            strobe_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg    <= cmd.emit_last;
            dropped_reg <= overflow_reg;
        end
    end

    assign count         = count_reg;
    assign greater       = (rd_a_reg > rd_b_reg);
    assign sorted_value  = rd_a_reg;
    assign result_strobe = strobe_reg;
    assign last_out      = last_reg;
    assign dropped       = dropped_reg;

    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= MAX_CNT, "element count past capacity")
    `ASSERT_IMPLIES(a_overflow_only_full, clk, rst_n, overflow_reg, count_reg == MAX_CNT,
        "overflow flagged while store not full")

endmodule

// ===== rtl/core/ssfg_ctrl.sv =====
// sequencer for load, gapped compare-and-swap passes and result readout
// depends on ssfg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssfg_ctrl #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             is_last,
    input  logic [CNT_W-1:0] count,
    input  logic             greater,
    output logic             busy,
    output ssfg_pkg::cmd_t   cmd,
    output logic [IDX_W-1:0] addr_lo,
    output logic [IDX_W-1:0] addr_hi
);

    // wide enough for an index plus the largest gap
    localparam int SUM_W = CNT_W + 3;

    ssfg_pkg::state_t state_reg;
    ssfg_pkg::state_t state_next;
    logic [SUM_W-1:0] idx_reg;
    logic [SUM_W-1:0] idx_next;
    logic [1:0]       step_reg;
    logic [1:0]       step_next;
    logic [1:0]       start_reg;
    logic [1:0]       start_next;
    logic             swapped_reg;
    logic             swapped_next;

    logic [SUM_W-1:0] gap;
    logic [SUM_W-1:0] hi_sum;
    logic [SUM_W-1:0] n_ext;
    logic             pair_ok;
    logic             out_last;

    assign gap      = SUM_W'(ssfg_pkg::gap_of(step_reg));
    assign hi_sum   = idx_reg + gap;
    assign n_ext    = SUM_W'(count);
    assign pair_ok  = (hi_sum < n_ext);
    assign out_last = ((idx_reg + SUM_W'(1)) == n_ext);

    // next state and loop counters
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        start_next   = start_reg;
        swapped_next = swapped_reg;
        case (state_reg)
            ssfg_pkg::ST_IDLE:
            begin
                if (start && is_last)
                begin
                    state_next   = ssfg_pkg::ST_PASS;
                    idx_next     = '0;
                    step_next    = ssfg_pkg::FIRST_STEP;
                    start_next   = '0;
                    swapped_next = 1'b0;
                end
            end
            ssfg_pkg::ST_PASS:
            begin
                if (pair_ok)
                begin
                    state_next = ssfg_pkg::ST_CMP;
                end
                else if (swapped_reg)
                begin
                    swapped_next = 1'b0;
                    idx_next     = SUM_W'(start_reg);
                end
                else if ((SUM_W'(start_reg) + SUM_W'(1)) < gap)
                begin
                    start_next = start_reg + 2'd1;
                    idx_next   = SUM_W'(start_reg) + SUM_W'(1);
                end
                else if (step_reg != 2'd0)
                begin
                    step_next  = step_reg - 2'd1;
                    start_next = '0;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ssfg_pkg::ST_OUT;
                    idx_next   = '0;
                end
            end
            ssfg_pkg::ST_CMP:
            begin
                if (greater)
                begin
                    state_next   = ssfg_pkg::ST_SWAP;
                    swapped_next = 1'b1;
                end
                else
                begin
                    state_next = ssfg_pkg::ST_PASS;
                    idx_next   = hi_sum;
                end
            end
            ssfg_pkg::ST_SWAP:
            begin
                state_next = ssfg_pkg::ST_PASS;
                idx_next   = hi_sum;
            end
            ssfg_pkg::ST_OUT:
            begin
                if (out_last)
                begin
                    state_next = ssfg_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SUM_W'(1);
                end
            end
            default:
            begin
                state_next = ssfg_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.wr_sel    = ssfg_pkg::WR_NONE;
        case (state_reg)
            ssfg_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            ssfg_pkg::ST_PASS:
            begin
                cmd.rd_en = pair_ok;
            end
            ssfg_pkg::ST_CMP:
            begin
                if (greater)
                begin
                    cmd.wr_sel = ssfg_pkg::WR_LOW;
                end
            end
            ssfg_pkg::ST_SWAP:
            begin
                cmd.wr_sel = ssfg_pkg::WR_HIGH;
            end
            ssfg_pkg::ST_OUT:
            begin
                cmd.rd_en     = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_last = out_last;
                cmd.clear     = out_last;
            end
            default: ;
        endcase
    end

    assign busy    = (state_reg != ssfg_pkg::ST_IDLE);
    assign addr_lo = idx_reg[IDX_W-1:0];
    assign addr_hi = hi_sum[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ssfg_pkg::ST_IDLE;
            idx_reg     <= '0;
            step_reg    <= '0;
            start_reg   <= '0;
            swapped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            start_reg   <= start_next;
            swapped_reg <= swapped_next;
        end
    end

    `ASSERT_IMPLIES(a_swap_after_cmp, clk, rst_n, state_reg == ssfg_pkg::ST_SWAP,
        $past(state_reg) == ssfg_pkg::ST_CMP, "swap write without a compare")
    `ASSERT_IMPLIES(a_pair_in_set, clk, rst_n, state_reg == ssfg_pkg::ST_CMP,
        hi_sum < n_ext, "compare pair outside the loaded set")
    `ASSERT_IMPLIES(a_out_in_set, clk, rst_n, state_reg == ssfg_pkg::ST_OUT,
        idx_reg < n_ext, "readout index outside the loaded set")

endmodule
